FILE: hw/rtl/lrm_pkg.sv
`default_nettype none
// ============================================================================
// lrm_pkg
// Shared types, codes and widths of the line pattern matcher.
// ============================================================================
package lrm_pkg;

    localparam int PATTERN_MAX_DEFAULT = 32;
    localparam int QUEUE_DEPTH         = 2;

    localparam int MODE_W    = 2;
    localparam int INDEX_W   = 5;
    localparam int KIND_W    = 3;
    localparam int CHAR_W    = 8;
    localparam int QUANT_W   = 2;
    localparam int QUARTER_W = 2;
    localparam int CLASS_W   = 64;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 6;

    localparam int CLASS_QUARTERS = 4;
    localparam int BIT_SEL_W      = 6;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_ELEM  = 2'd0,
        MODE_CLASS = 2'd1,
        MODE_BYTE  = 2'd2,
        MODE_EOL   = 2'd3
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_LITERAL  = 3'd0,
        KIND_ANY      = 3'd1,
        KIND_CLASS    = 3'd2,
        KIND_INVCLASS = 3'd3,
        KIND_NEVER    = 3'd4,
        KIND_END      = 3'd5
    } kind_t;

    typedef enum logic [QUANT_W-1:0] {
        Q_ONCE = 2'd0,
        Q_STAR = 2'd1,
        Q_PLUS = 2'd2,
        Q_OPT  = 2'd3
    } quant_t;

    typedef enum logic [PADDR_W-3:0] {
        REG_PATTERN_LENGTH = 1'd0,
        REG_ANCHORED_START = 1'd1
    } reg_index_t;

endpackage : lrm_pkg
`default_nettype wire

FILE: hw/rtl/lrm_channels.sv
`default_nettype none
// ============================================================================
// lrm_channels
// Valid/ready channels of the matcher: pattern and text items in, verdicts out.
// ============================================================================
interface lrm_stream_if;
    import lrm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [INDEX_W-1:0]   elem_index;
    logic [KIND_W-1:0]    elem_kind;
    logic [CHAR_W-1:0]    elem_char;
    logic [QUANT_W-1:0]   elem_quant;
    logic [QUARTER_W-1:0] class_quarter;
    logic [CLASS_W-1:0]   class_bits;
    logic [BYTE_W-1:0]    text_byte;

    modport source (
        output valid, mode, elem_index, elem_kind, elem_char, elem_quant,
               class_quarter, class_bits, text_byte,
        input  ready
    );

    modport sink (
        input  valid, mode, elem_index, elem_kind, elem_char, elem_quant,
               class_quarter, class_bits, text_byte,
        output ready
    );
endinterface : lrm_stream_if

interface lrm_verdict_if;
    logic valid;
    logic ready;
    logic line_matched;

    modport source (output valid, line_matched, input ready);
    modport sink (input valid, line_matched, output ready);
endinterface : lrm_verdict_if
`default_nettype wire

FILE: hw/rtl/line_regex_matcher_core.sv
`default_nettype none
// ============================================================================
// line_regex_matcher_core
// Line pattern matcher: searches each text line for a loaded pattern.
// ============================================================================
// Usage:
//   stream carries items: element loads, class map quarters, text bytes and
//   end-of-line markers. Load items take effect at the edge that accepts them.
//   verdict carries one line_matched bit for each end-of-line item.
//   The APB port holds pattern_length (0x0) and anchored_start (0x4);
//   write it only while no line is in flight. pready is always high.
// Throughput: one item per cycle, every mode, while stream.ready is high.
//   Each text byte is one pass of the NFA update (start injection, skip
//   closure on a (PATTERN_MAX+1)-bit add, byte step) in the back end.
// Verdict path: an accepted end-of-line item passes the front mask stage,
//   the queue and the back end, whose output register holds the verdict.
// Stall: the verdict is held in an output register; a two-entry queue lets
//   the front keep taking items while the back waits on the receiver. Once
//   the queue is full and the front stage holds an item, stream.ready drops.
// Reset: the NFA holds only the start position, the line is at its start,
//   both registers clear. Pattern tables are undefined until loaded.
// ============================================================================
module line_regex_matcher_core #(
    parameter int PATTERN_MAX = lrm_pkg::PATTERN_MAX_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    lrm_stream_if.sink                       stream,
    lrm_verdict_if.source                    verdict,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lrm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [lrm_pkg::PDATA_W-1:0] pwdata,
    output      logic [lrm_pkg::PDATA_W-1:0] prdata,
    output      logic                        pready
);
    import lrm_pkg::*;

    localparam int ENTRY_W = 5 * PATTERN_MAX + 4;

    logic [LEN_W-1:0]   pattern_length_reg;
    logic               anchored_start_reg;
    logic               cfg_we;
    reg_index_t         cfg_index;

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_not_empty;
    logic [ENTRY_W-1:0] q_entry;
    logic [ENTRY_W-1:0] q_head;

    assign pready    = 1'b1;
    assign cfg_we    = psel & penable & pwrite;
    assign cfg_index = reg_index_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            anchored_start_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[LEN_W-1:0];
                REG_ANCHORED_START: anchored_start_reg <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_PATTERN_LENGTH: prdata = PDATA_W'(pattern_length_reg);
            REG_ANCHORED_START: prdata = PDATA_W'(anchored_start_reg);
            default:            prdata = '0;
        endcase
    end

    lrm_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .stream         (stream),
        .pattern_length (pattern_length_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    lrm_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    lrm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .anchored_start (anchored_start_reg),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .verdict        (verdict)
    );
endmodule : line_regex_matcher_core
`default_nettype wire

FILE: hw/rtl/lrm_ram.sv
`default_nettype none
// ============================================================================
// lrm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module lrm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule : lrm_ram
`default_nettype wire

FILE: hw/rtl/lrm_front.sv
`default_nettype none
// ============================================================================
// lrm_front
// Accepts items, stores pattern elements and class maps, and turns each text
// or end-of-line item into per-position masks for the NFA back end.
// ============================================================================
module lrm_front #(
    parameter int PATTERN_MAX = lrm_pkg::PATTERN_MAX_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    lrm_stream_if.sink                     stream,
    input  wire logic [lrm_pkg::LEN_W-1:0] pattern_length,
    input  wire logic                      q_full,
    output      logic                      q_push,
    output      logic [5*PATTERN_MAX+3:0]  q_entry
);
    import lrm_pkg::*;

    localparam int P = PATTERN_MAX;

    logic              accept;
    logic              is_text;
    logic              elem_we;
    logic              class_we;

    logic [KIND_W-1:0]  kind_tab  [P];
    logic [CHAR_W-1:0]  char_tab  [P];
    logic [QUANT_W-1:0] quant_tab [P];
    logic [CLASS_W-1:0] class_rd  [P];

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_eol_reg;
    logic [BYTE_W-1:0] s1_byte_reg;

    logic [P-1:0] len_mask;
    logic [P-1:0] is_end;
    logic [P-1:0] below_end;
    logic [P-1:0] elem_live;
    logic [P-1:0] acc;
    logic [P-1:0] skip;
    logic [P-1:0] stay;
    logic [P-1:0] adv;
    logic [P:0]   pos_live;
    logic [P:0]   pos_end;
    logic         end_anch;

    assign accept   = stream.valid & stream.ready;
    assign is_text  = (stream.mode == MODE_BYTE) || (stream.mode == MODE_EOL);
    assign elem_we  = accept && (stream.mode == MODE_ELEM);
    assign class_we = accept && (stream.mode == MODE_CLASS);

    assign q_push       = s1_valid_reg & ~q_full;
    assign stream.ready = ~s1_valid_reg | ~q_full;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < P; i++)
        begin
            if (elem_we && (32'(stream.elem_index) == i))
            begin
                kind_tab[i]  <= stream.elem_kind;
                char_tab[i]  <= stream.elem_char;
                quant_tab[i] <= stream.elem_quant;
            end
        end
    end

    for (genvar g = 0; g < P; g++)
    begin : g_class
        lrm_ram #(
            .WIDTH (CLASS_W),
            .DEPTH (CLASS_QUARTERS)
        ) u_class_ram (
            .clk   (clk),
            .we    (class_we && (32'(stream.elem_index) == g)),
            .waddr (stream.class_quarter),
            .wdata (stream.class_bits),
            .re    (accept && (stream.mode == MODE_BYTE)),
            .raddr (stream.text_byte[BYTE_W-1 -: QUARTER_W]),
            .rdata (class_rd[g])
        );
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept && is_text)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_text)
        begin
            s1_eol_reg  <= (stream.mode == MODE_EOL);
            s1_byte_reg <= stream.text_byte;
        end
    end

    always_comb
    begin
        for (int i = 0; i < P; i++)
        begin
            len_mask[i] = (32'(pattern_length) > i);
            is_end[i]   = len_mask[i] && (kind_tab[i] == KIND_END);
            case (kind_tab[i])
                KIND_LITERAL:  acc[i] = (char_tab[i] == s1_byte_reg);
                KIND_ANY:      acc[i] = 1'b1;
                KIND_CLASS:    acc[i] = class_rd[i][s1_byte_reg[BIT_SEL_W-1:0]];
                KIND_INVCLASS: acc[i] = ~class_rd[i][s1_byte_reg[BIT_SEL_W-1:0]];
                default:       acc[i] = 1'b0;
            endcase
        end
        below_end = (is_end - P'(1)) & ~is_end;
        elem_live = len_mask & below_end;
        end_anch  = |is_end;
        pos_live  = {elem_live, 1'b1};
        pos_end   = pos_live & ~{1'b0, pos_live[P:1]};
        for (int i = 0; i < P; i++)
        begin
            skip[i] = elem_live[i] &&
                      ((quant_tab[i] == Q_STAR) || (quant_tab[i] == Q_OPT));
            stay[i] = elem_live[i] && acc[i] &&
                      ((quant_tab[i] == Q_STAR) || (quant_tab[i] == Q_PLUS));
            adv[i]  = elem_live[i] && acc[i] && (quant_tab[i] != Q_STAR);
        end
    end

    assign q_entry = {s1_eol_reg, end_anch, pos_live, pos_end, skip, stay, adv};

`ifndef SYNTHESIS
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && q_full) |=> (s1_valid_reg && $stable(s1_byte_reg)
                                      && $stable(s1_eol_reg)))
        else $error("front stage lost a stalled item");
`endif
endmodule : lrm_front
`default_nettype wire

FILE: hw/rtl/lrm_queue.sv
`default_nettype none
// ============================================================================
// lrm_queue
// Short register FIFO between the front end and the NFA back end.
// ============================================================================
module lrm_queue #(
    parameter int WIDTH = 164,
    parameter int DEPTH = lrm_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output      logic             full,
    input  wire logic             pop,
    output      logic             not_empty,
    output      logic [WIDTH-1:0] head
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("queue read while empty");
`endif
endmodule : lrm_queue
`default_nettype wire

FILE: hw/rtl/lrm_back.sv
`default_nettype none
// ============================================================================
// lrm_back
// Bit-parallel NFA: start injection, skip closure, byte step and line verdict.
// ============================================================================
module lrm_back #(
    parameter int PATTERN_MAX = lrm_pkg::PATTERN_MAX_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     anchored_start,
    input  wire logic                     q_not_empty,
    input  wire logic [5*PATTERN_MAX+3:0] q_head,
    output      logic                     q_pop,
    lrm_verdict_if.source                 verdict
);
    localparam int P = PATTERN_MAX;

    logic         eol;
    logic         end_anch;
    logic [P:0]   pos_live;
    logic [P:0]   pos_end;
    logic [P-1:0] skip;
    logic [P-1:0] stay;
    logic [P-1:0] adv;

    logic [P:0]   active_reg, active_next;
    logic         found_reg, found_next;
    logic         line_start_reg, line_start_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_bit_reg;

    logic         out_free;
    logic [P:0]   a_in;
    logic [P-1:0] gen;
    logic [P-1:0] prop;
    logic [P-1:0] add_x;
    logic [P:0]   sum;
    logic [P:0]   reach;
    logic         hit_end;
    logic [P:0]   step;

    assign {eol, end_anch, pos_live, pos_end, skip, stay, adv} = q_head;

    assign out_free = ~out_valid_reg | verdict.ready;
    assign q_pop    = q_not_empty & (~eol | out_free);

    always_comb
    begin
        a_in = active_reg;
        if (!anchored_start || line_start_reg)
        begin
            a_in[0] = 1'b1;
        end
        a_in    = a_in & pos_live;
        gen     = a_in[P:1];
        prop    = skip & ~gen;
        add_x   = gen | prop;
        sum     = {1'b0, add_x} + {1'b0, gen} + (P + 1)'(a_in[0]);
        reach   = {sum[P], sum[P-1:0] ^ add_x ^ gen};
        hit_end = |(reach & pos_end);
        step    = {1'b0, stay & reach[P-1:0]} | {adv & reach[P-1:0], 1'b0};
    end

    always_comb
    begin
        active_next     = active_reg;
        found_next      = found_reg;
        line_start_next = line_start_reg;
        out_valid_next  = out_valid_reg & ~verdict.ready;
        if (q_pop)
        begin
            if (eol)
            begin
                active_next     = (P + 1)'(1);
                found_next      = 1'b0;
                line_start_next = 1'b1;
                out_valid_next  = 1'b1;
            end
            else
            begin
                active_next     = step;
                found_next      = found_reg | (~end_anch & hit_end);
                line_start_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= (P + 1)'(1);
            found_reg      <= 1'b0;
            line_start_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            found_reg      <= found_next;
            line_start_reg <= line_start_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && eol)
        begin
            out_bit_reg <= found_reg | hit_end;
        end
    end

    assign verdict.valid        = out_valid_reg;
    assign verdict.line_matched = out_bit_reg;

`ifndef SYNTHESIS
    a_eol_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && eol) |=> verdict.valid)
        else $error("end of line without verdict");
    a_eol_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && eol) |=> (active_reg == (P + 1)'(1) && !found_reg && line_start_reg))
        else $error("matcher not rearmed after end of line");
`endif
endmodule : lrm_back
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for line_regex_matcher_core. It loads pattern elements
// and class maps, streams text lines and end-of-line items under random
// source gaps and sink stalls, and compares every line_matched verdict with an
// NFA model kept alongside the block. Both APB registers are written
// and read back across several settings.
// ============================================================================
module tb;
    import lrm_pkg::*;

    localparam int          PAT_MAX      = PATTERN_MAX_DEFAULT;
    localparam int          RANDOM_ITEMS = 230;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [2:0]  KIND_SPARE_6 = 3'd6;
    localparam logic [2:0]  KIND_SPARE_7 = 3'd7;

    typedef struct {
        mode_t                mode;
        logic [INDEX_W-1:0]   elem_index;
        logic [KIND_W-1:0]    elem_kind;
        logic [CHAR_W-1:0]    elem_char;
        quant_t               elem_quant;
        logic [QUARTER_W-1:0] class_quarter;
        logic [CLASS_W-1:0]   class_bits;
        logic [BYTE_W-1:0]    text_byte;
    } stream_item_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    lrm_stream_if  stream_ch ();
    lrm_verdict_if verdict_ch ();

    line_regex_matcher_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_ch),
        .verdict (verdict_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [KIND_W-1:0]  pat_kind  [PAT_MAX];
    logic [CHAR_W-1:0]  pat_char  [PAT_MAX];
    quant_t             pat_quant [PAT_MAX];
    logic [CLASS_W-1:0] pat_class [PAT_MAX*CLASS_QUARTERS];
    logic [PAT_MAX:0]   nfa_live;
    bit                 seen_match;
    bit                 line_fresh;
    logic [LEN_W-1:0]   cfg_len;
    bit                 cfg_anchor;

    bit match_expected[$];
    bit want;
    bit steady;
    int errors;
    int items_sent;
    int lines_checked;
    int settings_used;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: done, errors");
        $finish;
    end

    function automatic int live_end(output bit cut);
        int lim;
        int i;
        cut = 1'b0;
        lim = (cfg_len > PAT_MAX) ? PAT_MAX : int'(cfg_len);
        for (i = 0; i < lim; i++)
        begin
            if (pat_kind[i] == KIND_END)
            begin
                cut = 1'b1;
                return i;
            end
        end
        return lim;
    endfunction

    function automatic bit elem_takes(int i, logic [7:0] b);
        logic [CLASS_W-1:0] w;
        bit                 hit;
        w   = pat_class[i*CLASS_QUARTERS + int'(b[7:6])];
        hit = w[b[5:0]];
        case (pat_kind[i])
            KIND_LITERAL:  return pat_char[i] == b;
            KIND_ANY:      return 1'b1;
            KIND_CLASS:    return hit;
            KIND_INVCLASS: return !hit;
            default:       return 1'b0;
        endcase
    endfunction

    task automatic nfa_accept(input stream_item_t it);
        int               e;
        int               i;
        bit               cut;
        logic [PAT_MAX:0] nxt;
        case (it.mode)
            MODE_ELEM:
            begin
                pat_kind[it.elem_index]  = it.elem_kind;
                pat_char[it.elem_index]  = it.elem_char;
                pat_quant[it.elem_index] = it.elem_quant;
            end
            MODE_CLASS:
            begin
                pat_class[{it.elem_index, it.class_quarter}] = it.class_bits;
            end
            default:
            begin
                e = live_end(cut);
                if (!cfg_anchor || line_fresh)
                    nfa_live[0] = 1'b1;
                for (i = e + 1; i <= PAT_MAX; i++)
                    nfa_live[i] = 1'b0;
                for (i = 0; i < e; i++)
                begin
                    if (nfa_live[i] && (pat_quant[i] == Q_STAR || pat_quant[i] == Q_OPT))
                        nfa_live[i+1] = 1'b1;
                end
                if (it.mode == MODE_BYTE)
                begin
                    if (!cut && nfa_live[e])
                        seen_match = 1'b1;
                    nxt = '0;
                    for (i = 0; i < e; i++)
                    begin
                        if (nfa_live[i] && elem_takes(i, it.text_byte))
                        begin
                            case (pat_quant[i])
                                Q_STAR: nxt[i] = 1'b1;
                                Q_PLUS:
                                begin
                                    nxt[i]   = 1'b1;
                                    nxt[i+1] = 1'b1;
                                end
                                default: nxt[i+1] = 1'b1;
                            endcase
                        end
                    end
                    nfa_live   = nxt;
                    line_fresh = 1'b0;
                end
                else
                begin
                    match_expected.push_back(seen_match || nfa_live[e]);
                    nfa_live   = (PAT_MAX + 1)'(1);
                    seen_match = 1'b0;
                    line_fresh = 1'b1;
                end
            end
        endcase
    endtask

    function automatic stream_item_t any_item(mode_t m);
        stream_item_t it;
        it.mode          = m;
        it.elem_index    = INDEX_W'($urandom_range(0, PAT_MAX - 1));
        it.elem_kind     = KIND_W'($urandom_range(0, 7));
        it.elem_char     = CHAR_W'($urandom_range(0, 255));
        it.elem_quant    = quant_t'($urandom_range(0, 3));
        it.class_quarter = QUARTER_W'($urandom_range(0, CLASS_QUARTERS - 1));
        it.class_bits    = {$urandom, $urandom};
        it.text_byte     = BYTE_W'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic send_item(input stream_item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_ch.valid         <= 1'b1;
        stream_ch.mode          <= it.mode;
        stream_ch.elem_index    <= it.elem_index;
        stream_ch.elem_kind     <= it.elem_kind;
        stream_ch.elem_char     <= it.elem_char;
        stream_ch.elem_quant    <= it.elem_quant;
        stream_ch.class_quarter <= it.class_quarter;
        stream_ch.class_bits    <= it.class_bits;
        stream_ch.text_byte     <= it.text_byte;
        do @(posedge clk); while (!stream_ch.ready);
        nfa_accept(it);
        items_sent++;
    endtask

    task automatic send_elem(int idx, logic [2:0] kind, logic [7:0] chr, quant_t q);
        stream_item_t it;
        it            = any_item(MODE_ELEM);
        it.elem_index = INDEX_W'(idx);
        it.elem_kind  = kind;
        it.elem_char  = chr;
        it.elem_quant = q;
        send_item(it);
    endtask

    task automatic send_class(int idx, int quarter, logic [CLASS_W-1:0] bits);
        stream_item_t it;
        it               = any_item(MODE_CLASS);
        it.elem_index    = INDEX_W'(idx);
        it.class_quarter = QUARTER_W'(quarter);
        it.class_bits    = bits;
        send_item(it);
    endtask

    task automatic send_text(logic [7:0] b);
        stream_item_t it;
        it           = any_item(MODE_BYTE);
        it.text_byte = b;
        send_item(it);
    endtask

    task automatic send_line(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_text(s[i]);
        send_item(any_item(MODE_EOL));
    endtask

    task automatic settle();
        stream_ch.valid <= 1'b0;
        while (match_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(reg_index_t r, logic [PDATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (r)
            REG_PATTERN_LENGTH: cfg_len    = v[LEN_W-1:0];
            REG_ANCHORED_START: cfg_anchor = v[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic reg_check(reg_index_t r, logic [PDATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== v)
        begin
            $error("prdata[%s]: expected %0h, actual %0h", r.name(), v, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(int len, bit anch);
        reg_write(REG_PATTERN_LENGTH, PDATA_W'(len));
        reg_write(REG_ANCHORED_START, PDATA_W'(anch));
        reg_check(REG_PATTERN_LENGTH, PDATA_W'(len));
        reg_check(REG_ANCHORED_START, PDATA_W'(anch));
        settings_used++;
    endtask

    function automatic logic [7:0] line_char();
        if ($urandom_range(0, 6) == 0)
            return 8'($urandom_range(0, 255));
        return 8'h61 + 8'($urandom_range(0, 3));
    endfunction

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)   return KIND_LITERAL;
        if (r < 10)  return KIND_ANY;
        if (r < 13)  return KIND_CLASS;
        if (r < 15)  return KIND_INVCLASS;
        if (r == 15) return KIND_NEVER;
        if (r < 18)  return KIND_END;
        if (r == 18) return KIND_SPARE_6;
        return KIND_SPARE_7;
    endfunction

    task automatic test_table_load();
        int i;
        for (i = 0; i < PAT_MAX; i++)
            send_elem(i, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      quant_t'($urandom_range(0, 3)));
        for (i = 0; i < PAT_MAX * CLASS_QUARTERS; i++)
            send_class(i / CLASS_QUARTERS, i % CLASS_QUARTERS, {$urandom, $urandom});
    endtask

    task automatic test_literal_quantifiers();
        settle();
        apply_settings(3, 1'b0);
        send_elem(0, KIND_LITERAL, "a", Q_ONCE);
        send_elem(1, KIND_CLASS, 8'h00, Q_PLUS);
        send_class(1, 1, 64'h3 << 34);
        send_elem(2, KIND_LITERAL, "d", Q_OPT);
        send_line("xabbd");
        send_line("ac");
    endtask

    task automatic test_end_anchor();
        send_elem(2, KIND_END, 8'h00, Q_ONCE);
        send_line("abc");
        send_line("abcx");
    endtask

    task automatic test_anchor_and_odd_kinds();
        settle();
        apply_settings(63, 1'b1);
        send_elem(0, KIND_ANY, 8'h00, Q_STAR);
        send_elem(1, KIND_INVCLASS, 8'h00, Q_ONCE);
        send_class(1, 3, 64'h8000_0000_0000_0000);
        send_elem(2, KIND_NEVER, 8'hff, Q_OPT);
        send_elem(3, KIND_SPARE_6, 8'h00, Q_STAR);
        send_elem(4, KIND_SPARE_7, 8'h00, Q_OPT);
        send_elem(5, KIND_LITERAL, 8'h00, Q_ONCE);
        send_elem(6, KIND_END, 8'h00, Q_ONCE);
        send_text(8'h41);
        send_text(8'h00);
        send_item(any_item(MODE_EOL));
        send_text(8'hff);
        send_text(8'h00);
        send_item(any_item(MODE_EOL));
    endtask

    task automatic test_empty_pattern();
        settle();
        apply_settings(0, 1'b0);
        send_item(any_item(MODE_EOL));
        send_line("z");
    endtask

    task automatic test_random_lines();
        int         first;
        int         len;
        int         k;
        int         i;
        int         j;
        int         nlines;
        int         nbytes;
        logic [2:0] kind;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = $urandom_range(PAT_MAX, 63);
                default: len = $urandom_range(1, 6);
            endcase
            apply_settings(len, $urandom_range(0, 1) == 1);
            steady = ($urandom_range(0, 3) == 0);
            k = (len > 6) ? 6 : len;
            for (i = 0; i < k; i++)
            begin
                kind = pick_kind();
                send_elem(i, kind, line_char(), quant_t'($urandom_range(0, 3)));
                if (kind == KIND_CLASS || kind == KIND_INVCLASS)
                    send_class(i, 1, {$urandom, $urandom});
            end
            nlines = $urandom_range(2, 6);
            for (i = 0; i < nlines; i++)
            begin
                nbytes = $urandom_range(0, 12);
                for (j = 0; j < nbytes; j++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(any_item(mode_t'($urandom_range(0, 3))));
                    else
                        send_text(line_char());
                end
                send_item(any_item(MODE_EOL));
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        verdict_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!steady && $urandom_range(0, 1) == 0)
            begin
                verdict_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            verdict_ch.ready <= 1'b1;
            do @(posedge clk); while (!(verdict_ch.valid && verdict_ch.ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            if (match_expected.size() == 0)
            begin
                $error("line_matched: expected none, actual %0b", verdict_ch.line_matched);
                errors++;
            end
            else
            begin
                want = match_expected.pop_front();
                lines_checked++;
                if (verdict_ch.line_matched !== want)
                begin
                    $error("line_matched: expected %0b, actual %0b",
                           want, verdict_ch.line_matched);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n                   <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        stream_ch.valid         <= 1'b0;
        stream_ch.mode          <= MODE_ELEM;
        stream_ch.elem_index    <= '0;
        stream_ch.elem_kind     <= '0;
        stream_ch.elem_char     <= '0;
        stream_ch.elem_quant    <= Q_ONCE;
        stream_ch.class_quarter <= '0;
        stream_ch.class_bits    <= '0;
        stream_ch.text_byte     <= '0;
        nfa_live                 = (PAT_MAX + 1)'(1);
        seen_match               = 1'b0;
        line_fresh               = 1'b1;
        cfg_len                  = '0;
        cfg_anchor               = 1'b0;
        steady                   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_literal_quantifiers();
        test_end_anchor();
        test_anchor_and_odd_kinds();
        test_empty_pattern();
        test_random_lines();

        settle();
        if (match_expected.size() != 0)
        begin
            $error("line_matched: %0d verdicts never arrived", match_expected.size());
            errors++;
        end
        $display("tb: %0d items sent, %0d line verdicts compared, %0d register settings",
                 items_sent, lines_checked, settings_used);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule : tb
